FILE: src/xlsu_pkg.sv
// Shared types and constants of the x86 logic and shift unit.
package xlsu_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [3:0] {
    ACT_TEST  = 4'd0,
    ACT_AND   = 4'd1,
    ACT_OR    = 4'd2,
    ACT_XOR   = 4'd3,
    ACT_NOT   = 4'd4,
    ACT_SHL   = 4'd5,
    ACT_SHR   = 4'd6,
    ACT_SAR   = 4'd7,
    ACT_SETCC = 4'd8
  } action_t;

  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_WORD = 2'd1;

  localparam logic [3:0] CC_MASK = 4'hf;
  localparam logic [3:0] CC_P    = 4'd10;
  localparam logic [3:0] CC_NP   = 4'd11;

  typedef struct packed {
    logic [3:0]        action;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
    logic [1:0]        operand_width;
    logic [3:0]        cond_code;
    logic              carry_in;
    logic              overflow_in;
    logic              zero_in;
    logic              sign_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              write_result;
    logic              carry_out;
    logic              overflow_out;
    logic              zero_out;
    logic              sign_out;
    logic              cond_unsupported;
  } res_t;

  // Mask of the operand bits; width code 3 acts as doubleword.
  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] w);
    logic [DATA_W-1:0] m;
    begin
      unique case (w)
        WIDTH_BYTE: m = {{(DATA_W-8){1'b0}}, 8'hff};
        WIDTH_WORD: m = {{(DATA_W-16){1'b0}}, 16'hffff};
        default:    m = {DATA_W{1'b1}};
      endcase
      return m;
    end
  endfunction

endpackage

FILE: src/x86_logic_shift_unit.sv
// Top level of the x86 logic and shift execute unit with its request registers.
// This unit executes one x86 logic-group instruction (test, and, or, xor, not,
// shl, shr, sar, setcc) per request on a byte, word or doubleword operand and
// returns the truncated result, a write-back enable, the updated CF/OF/ZF/SF
// flags and a marker for the unsupported parity conditions of setcc. A request
// is captured into an input register, passes through one level of short
// combinational logic and lands in a result register, which drives the output.
// One new request can be accepted every cycle while the output stall does not
// back up both register stages. Both channels use valid and stall; the
// output stall reaches the input stall combinationally through the two
// register stages, and the unit holds at most two requests in flight. The unit
// keeps no architectural state, so nothing has to be configured or cleared.
module x86_logic_shift_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [31:0] dest_value,
  input  logic [31:0] src_value,
  input  logic [1:0]  operand_width,
  input  logic [3:0]  cond_code,
  input  logic        carry_in,
  input  logic        overflow_in,
  input  logic        zero_in,
  input  logic        sign_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        write_result,
  output logic        carry_out,
  output logic        overflow_out,
  output logic        zero_out,
  output logic        sign_out,
  output logic        cond_unsupported
);
  import xlsu_pkg::*;

  // Input register stage.
  req_t req_reg;
  logic req_valid;
  // Result register stage.
  res_t res_reg;
  logic res_valid;

  res_t res_next;
  logic res_ready;
  logic req_ready;

  // The result register can take a new value when it is empty or being drained.
  assign res_ready = !res_valid || !out_stall;
  // The input register can take a new request when it is empty or moving on.
  assign req_ready = !req_valid || res_ready;
  assign in_stall  = !req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && in_valid) begin
      req_reg.action        <= action;
      req_reg.dest_value    <= dest_value;
      req_reg.src_value     <= src_value;
      req_reg.operand_width <= operand_width;
      req_reg.cond_code     <= cond_code;
      req_reg.carry_in      <= carry_in;
      req_reg.overflow_in   <= overflow_in;
      req_reg.zero_in       <= zero_in;
      req_reg.sign_in       <= sign_in;
    end
  end

  // All of the instruction's work happens in this single combinational pass.
  xlsu_exec u_exec (
    .req (req_reg),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && req_valid) begin
      res_reg <= res_next;
    end
  end

  assign out_valid        = res_valid;
  assign result_value     = res_reg.result_value;
  assign write_result     = res_reg.write_result;
  assign carry_out        = res_reg.carry_out;
  assign overflow_out     = res_reg.overflow_out;
  assign zero_out         = res_reg.zero_out;
  assign sign_out         = res_reg.sign_out;
  assign cond_unsupported = res_reg.cond_unsupported;

`ifndef NO_ASSERTIONS
  // A request in the input register moves to the output when there is room.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    req_valid && res_ready |=> res_valid)
    else $error("request in input register was not moved to result register");

  // A request held back by a stalled output stays in the input register.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !res_ready |=> req_valid && $stable(req_reg))
    else $error("held request was lost or changed");

  // An unsupported parity condition always yields a zero, written result.
  a_unsup: assert property (@(posedge clk) disable iff (rst)
    res_valid && cond_unsupported |-> result_value == '0 && write_result)
    else $error("unsupported condition produced a nonzero result");

  // No request is accepted while both register stages are full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_valid && res_valid && out_stall |-> in_stall)
    else $error("request accepted while pipeline is full");
`endif

endmodule

FILE: src/xlsu_shift.sv
// Barrel shifter for shl, shr and sar at byte, word or doubleword width.
module xlsu_shift (
  input  logic [xlsu_pkg::DATA_W-1:0]  operand,
  input  logic [1:0]                   operand_width,
  input  logic [xlsu_pkg::COUNT_W-1:0] count,
  input  xlsu_pkg::action_t            action,
  output logic [xlsu_pkg::DATA_W-1:0]  shifted
);
  import xlsu_pkg::*;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] ext;
  logic              msb;

  always_comb begin
    mask = width_mask(operand_width);
    unique case (operand_width)
      WIDTH_BYTE: msb = operand[7];
      WIDTH_WORD: msb = operand[15];
      default:    msb = operand[DATA_W-1];
    endcase
    // Sign-extend from the operand width before the arithmetic shift.
    ext = msb ? (operand | ~mask) : operand;
  end

  always_comb begin
    unique case (action)
      ACT_SHL: shifted = operand << count;
      ACT_SHR: shifted = operand >> count;
      ACT_SAR: shifted = DATA_W'($signed(ext) >>> count);
      default: shifted = '0;
    endcase
  end

endmodule

FILE: src/xlsu_exec.sv
// Combinational execute logic: logic ops, shifts, setcc and flag update.
module xlsu_exec (
  input  xlsu_pkg::req_t req,
  output xlsu_pkg::res_t res
);
  import xlsu_pkg::*;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] d;
  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] value;
  logic              sign_bit;
  logic              cond_true;
  logic              cond_base;
  logic [3:0]        cc;
  logic              logic_flags;
  logic              zs_flags;
  logic              wr;
  logic              unsup;

  assign mask = width_mask(req.operand_width);
  assign d    = req.dest_value & mask;
  assign cc   = req.cond_code & CC_MASK;

  xlsu_shift u_shift (
    .operand       (d),
    .operand_width (req.operand_width),
    .count         (req.src_value[COUNT_W-1:0]),
    .action        (action_t'(req.action)),
    .shifted       (shifted)
  );

  // Condition pairs: odd codes are the negated form of the even ones.
  always_comb begin
    unique case (cc[3:1])
      3'd0:    cond_base = req.overflow_in;
      3'd1:    cond_base = req.carry_in;
      3'd2:    cond_base = req.zero_in;
      3'd3:    cond_base = req.carry_in | req.zero_in;
      3'd4:    cond_base = req.sign_in;
      3'd6:    cond_base = req.sign_in ^ req.overflow_in;
      3'd7:    cond_base = req.zero_in | (req.sign_in ^ req.overflow_in);
      default: cond_base = 1'b0;
    endcase
    cond_true = cond_base ^ cc[0];
  end

  always_comb begin
    raw         = '0;
    wr          = 1'b1;
    unsup       = 1'b0;
    logic_flags = 1'b0;
    zs_flags    = 1'b0;
    unique case (req.action)
      ACT_TEST: begin
        raw = d & req.src_value; wr = 1'b0; logic_flags = 1'b1;
      end
      ACT_AND: begin
        raw = d & req.src_value; logic_flags = 1'b1;
      end
      ACT_OR: begin
        raw = d | req.src_value; logic_flags = 1'b1;
      end
      ACT_XOR: begin
        raw = d ^ req.src_value; logic_flags = 1'b1;
      end
      ACT_NOT: raw = ~d;
      ACT_SHL, ACT_SHR, ACT_SAR: begin
        raw = shifted; zs_flags = 1'b1;
      end
      ACT_SETCC: begin
        if (cc == CC_P || cc == CC_NP) begin
          unsup = 1'b1;
        end else begin
          raw = {{(DATA_W-1){1'b0}}, cond_true};
        end
      end
      default: wr = 1'b0;
    endcase
  end

  assign value = raw & mask;

  always_comb begin
    unique case (req.operand_width)
      WIDTH_BYTE: sign_bit = value[7];
      WIDTH_WORD: sign_bit = value[15];
      default:    sign_bit = value[DATA_W-1];
    endcase
  end

  always_comb begin
    res.result_value     = value;
    res.write_result     = wr;
    res.cond_unsupported = unsup;
    res.carry_out        = logic_flags ? 1'b0 : req.carry_in;
    res.overflow_out     = logic_flags ? 1'b0 : req.overflow_in;
    res.zero_out         = (logic_flags || zs_flags) ? (value == '0) : req.zero_in;
    res.sign_out         = (logic_flags || zs_flags) ? sign_bit : req.sign_in;
  end

endmodule
